FILE: rtl/pekq_pkg.sv
// Shared constants, types and the button remap for the pad edge key queue.
`timescale 1ns / 1ps

package pekq_pkg;

  // Default number of slots in the key ring; one slot always stays free.
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KEY_W   = 8;
  localparam int COUNT_W = 4;
  localparam int RAW_W   = 32;

  // Raw bit that marks a controller word as invalid.
  localparam int RAW_INVALID_BIT = 31;

  // Key codes, in the order in which newly pressed buttons are queued:
  // up, down, left, right, fire, use, tab, escape.
  localparam logic [KEY_W-1:0] EDGE_CODE [8] = '{
    8'hAD, 8'hAF, 8'hAC, 8'hAE, 8'h9D, 8'h20, 8'h09, 8'h1B
  };

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_PUSH = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // Builds the button byte from the raw controller word. Bit 3 of the byte is
  // the start bit, set by either of the two start-like buttons.
  function automatic logic [KEY_W-1:0] remap_buttons(input logic [RAW_W-1:0] raw);
    logic [KEY_W-1:0] r;
    r[0] = raw[14];
    r[1] = raw[15];
    r[2] = raw[12];
    r[3] = raw[13] | raw[3];
    r[4] = raw[4];
    r[5] = raw[6];
    r[6] = raw[7];
    r[7] = raw[5];
    return r;
  endfunction

endpackage

FILE: rtl/pekq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pekq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pad_edge_key_queue.sv
// Top level of the pad edge key queue: edge detector, push sequencer and key ring.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | command, sample_valid, raw_buttons
//  out_    | output    | out_valid/out_ready| key_code, queued_count
//
// Every item yields exactly one result item. A pop passes through S_POP, where
// the registered read data of the ring memory is taken up, then through S_FIN,
// where its result is loaded; an empty ring goes straight to S_FIN. A valid
// sample runs the push sequencer, which visits the eight buttons one per cycle
// and writes at most one code per cycle through the ring's single write port.
// An invalid sample goes straight to S_FIN.
// Reset (rst_n low, synchronous) empties the ring by clearing both pointers
// and clears the previous button byte; ring contents are left as they are.
// A new item is taken once the previous one has been finished; a result that
// waits on out_ready holds only the last step of the following item.

module pad_edge_key_queue #(
  parameter int QUEUE_DEPTH = pekq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic                          in_sample_valid,
  input  logic [pekq_pkg::RAW_W-1:0]    in_raw_buttons,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pekq_pkg::KEY_W-1:0]    out_key_code,
  output logic [pekq_pkg::COUNT_W-1:0]  out_queued_count
);

  import pekq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [KEY_W-1:0]  last_r, last_nxt;
  logic [KEY_W-1:0]  rise_r, rise_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [KEY_W-1:0]  code_r, code_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic              in_fire;
  logic [KEY_W-1:0]  now_buttons;
  logic [PTR_W-1:0]  wr_inc, rd_inc;
  logic              full;
  logic [PTR_W:0]    count_wide;
  logic [PTR_W+COUNT_W-1:0] count_ext;
  logic              push_bit;

  logic              mem_we, mem_re;
  logic [KEY_W-1:0]  mem_rdata;

  // Pointers wrap at the ring depth, which need not be a power of two.
  assign wr_inc = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
  assign full   = (wr_inc == rd_r);

  // Codes held in the ring (always below the depth), then cut or padded to the
  // four-bit count field.
  assign count_wide = (wr_r >= rd_r) ?
                      ({1'b0, wr_r} - {1'b0, rd_r}) :
                      ({1'b0, wr_r} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, rd_r});
  assign count_ext  = {{COUNT_W{1'b0}}, count_wide[PTR_W-1:0]};

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign now_buttons = remap_buttons(in_raw_buttons);

  // The sequencer walks up, down, left, right (byte bits 4 to 7) and then
  // fire, use, tab, escape (byte bits 0 to 3).
  assign push_bit = rise_r[{~idx_r[2], idx_r[1:0]}];

  // Reads happen only in a pop and writes only during the push sequence, and
  // one item is worked on at a time, so the two ports never meet on an entry.
  assign mem_re = in_fire && in_command && (rd_r != wr_r);
  assign mem_we = (state_r == S_PUSH) && push_bit && !full;

  pekq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_r),
    .wdata (EDGE_CODE[idx_r]),
    .re    (mem_re),
    .raddr (rd_r),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    last_nxt      = last_r;
    rise_nxt      = rise_r;
    idx_nxt       = idx_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          code_nxt = '0;
          if (in_command) begin
            // An empty ring answers a pop with a zero code.
            state_nxt = (rd_r != wr_r) ? S_POP : S_FIN;
          end else if (in_sample_valid && !in_raw_buttons[RAW_INVALID_BIT]) begin
            last_nxt  = now_buttons;
            rise_nxt  = now_buttons & ~last_r;
            idx_nxt   = '0;
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_POP: begin
        code_nxt  = mem_rdata;
        rd_nxt    = rd_inc;
        state_nxt = S_FIN;
      end
      S_PUSH: begin
        // A push into a full ring is dropped; the later buttons are still tried.
        if (mem_we) begin
          wr_nxt = wr_inc;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 3'd7) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = code_r;
          out_cnt_nxt   = count_ext[COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_r        <= '0;
      wr_r        <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rise_r    <= rise_nxt;
    idx_r     <= idx_nxt;
    code_r    <= code_nxt;
    out_key_r <= out_key_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_key_code     = out_key_r;
  assign out_queued_count = out_cnt_r;

  // Both pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(rd_r) < QUEUE_DEPTH) && (32'(wr_r) < QUEUE_DEPTH))
    else $error("ring pointer out of range");

  // A write never lands on the slot that keeps a full ring distinct from empty.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !full)
    else $error("push into a full ring");

  // The read pointer does not move while codes are being pushed.
  a_rd_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |=> (rd_r == $past(rd_r)))
    else $error("read pointer moved during push sequence");

  // A pop that reads the memory moves on to the pop step, where the read pointer advances.
  a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (state_r == S_POP))
    else $error("memory read without pop step");

  // An accepted item leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted item was not taken up");

endmodule

FILE: tb/sv/pekq_tb_pkg.sv
// Testbench-side names for the pad edge key queue: commands, raw button masks and key codes.
`timescale 1ns / 1ps

package pekq_tb_pkg;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_POP    = 1'b1
  } pad_cmd_t;

  // Raw controller bits that reach the button byte.
  localparam logic [31:0] RAW_FIRE    = 32'h0000_4000;
  localparam logic [31:0] RAW_USE     = 32'h0000_8000;
  localparam logic [31:0] RAW_TAB     = 32'h0000_1000;
  localparam logic [31:0] RAW_START_A = 32'h0000_2000;
  localparam logic [31:0] RAW_START_B = 32'h0000_0008;
  localparam logic [31:0] RAW_UP      = 32'h0000_0010;
  localparam logic [31:0] RAW_DOWN    = 32'h0000_0040;
  localparam logic [31:0] RAW_LEFT    = 32'h0000_0080;
  localparam logic [31:0] RAW_RIGHT   = 32'h0000_0020;

  localparam logic [31:0] RAW_BUTTON_MASK = RAW_FIRE | RAW_USE | RAW_TAB | RAW_START_A |
                                            RAW_START_B | RAW_UP | RAW_DOWN | RAW_LEFT |
                                            RAW_RIGHT;
  localparam logic [31:0] RAW_KEEP_MASK   = 32'h001F_FFFF;
  localparam logic [31:0] RAW_BAD_FLAG    = 32'h8000_0000;

  localparam logic [7:0] CODE_UP    = 8'hAD;
  localparam logic [7:0] CODE_DN    = 8'hAF;
  localparam logic [7:0] CODE_LT    = 8'hAC;
  localparam logic [7:0] CODE_RT    = 8'hAE;
  localparam logic [7:0] CODE_SHOOT = 8'h9D;
  localparam logic [7:0] CODE_USE   = 8'h20;
  localparam logic [7:0] CODE_TAB   = 8'h09;
  localparam logic [7:0] CODE_ESC   = 8'h1B;

  // Button byte bit of each key, listed in the order new presses are queued.
  localparam logic [7:0] PRESS_BIT [8] = '{
    8'h10, 8'h20, 8'h40, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08
  };
  localparam logic [7:0] PRESS_KEY [8] = '{
    CODE_UP, CODE_DN, CODE_LT, CODE_RT, CODE_SHOOT, CODE_USE, CODE_TAB, CODE_ESC
  };

endpackage

FILE: tb/sv/pekq_key_checker.sv
// Watches both channels of the pad edge key queue, predicts each result and compares it.
`timescale 1ns / 1ps

module pekq_key_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic        in_sample_valid,
  input  logic [31:0] in_raw_buttons,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_key_code,
  input  logic [3:0]  out_queued_count,
  output int          error_count,
  output int          pending_count,
  output int          result_count,
  output int          popped_codes,
  output int          dropped_codes
);
  import pekq_tb_pkg::*;

  typedef struct packed {
    logic [7:0] key_code;
    logic [3:0] queued_count;
  } key_result_t;

  key_result_t awaited_results[$];

  // Shadow copy of the ring; 4-bit pointers wrap at the default depth of 16.
  logic [7:0] shadow_ring [16];
  logic [3:0] head_ptr;
  logic [3:0] tail_ptr;
  logic [7:0] held_buttons;

  initial begin
    error_count   = 0;
    pending_count = 0;
    result_count  = 0;
    popped_codes  = 0;
    dropped_codes = 0;
  end

  function automatic logic [7:0] button_byte(input logic [31:0] raw);
    logic [31:0] kept;
    logic [7:0]  b;
    kept = raw & RAW_KEEP_MASK;
    b[0] = |(kept & RAW_FIRE);
    b[1] = |(kept & RAW_USE);
    b[2] = |(kept & RAW_TAB);
    b[3] = |(kept & (RAW_START_A | RAW_START_B));
    b[4] = |(kept & RAW_UP);
    b[5] = |(kept & RAW_DOWN);
    b[6] = |(kept & RAW_LEFT);
    b[7] = |(kept & RAW_RIGHT);
    return b;
  endfunction

  task automatic predict_item(input logic cmd, input logic sample_ok, input logic [31:0] raw);
    key_result_t r;
    logic [7:0]  now_buttons;
    logic [7:0]  rising;
    logic [3:0]  next_tail;
    r.key_code = '0;
    if (cmd == CMD_POP) begin
      if (head_ptr != tail_ptr) begin
        r.key_code = shadow_ring[head_ptr];
        head_ptr = head_ptr + 4'd1;
        popped_codes++;
      end
    end else if (sample_ok && !raw[pekq_pkg::RAW_INVALID_BIT]) begin
      now_buttons  = button_byte(raw);
      rising       = now_buttons & ~held_buttons;
      held_buttons = now_buttons;
      for (int i = 0; i < 8; i++) begin
        if ((rising & PRESS_BIT[i]) != '0) begin
          next_tail = tail_ptr + 4'd1;
          if (next_tail != head_ptr) begin
            shadow_ring[tail_ptr] = PRESS_KEY[i];
            tail_ptr = next_tail;
          end else begin
            dropped_codes++;
          end
        end
      end
    end
    r.queued_count = tail_ptr - head_ptr;
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      head_ptr     = '0;
      tail_ptr     = '0;
      held_buttons = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: key_code %h queued_count %0d",
                 out_key_code, out_queued_count);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_key_code !== want.key_code) begin
            $error("key_code: expected %h, actual %h", want.key_code, out_key_code);
            error_count++;
          end
          if (out_queued_count !== want.queued_count) begin
            $error("queued_count: expected %0d, actual %0d",
                   want.queued_count, out_queued_count);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_item(in_command, in_sample_valid, in_raw_buttons);
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

FILE: tb/sv/pad_edge_key_queue_tb.sv
// Top of the pad edge key queue testbench: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module pad_edge_key_queue_tb;
  import pekq_tb_pkg::*;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_command      = CMD_SAMPLE;
  logic        in_sample_valid = 1'b0;
  logic [31:0] in_raw_buttons  = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [7:0]  out_key_code;
  logic [3:0]  out_queued_count;

  int error_count;
  int pending_count;
  int result_count;
  int popped_codes;
  int dropped_codes;

  // While this is set, neither the sender nor the receiver idles.
  logic steady_flow = 1'b0;
  int   items_sent  = 0;

  pad_edge_key_queue DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sample_valid  (in_sample_valid),
    .in_raw_buttons   (in_raw_buttons),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_code     (out_key_code),
    .out_queued_count (out_queued_count)
  );

  pekq_key_checker key_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sample_valid  (in_sample_valid),
    .in_raw_buttons   (in_raw_buttons),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_code     (out_key_code),
    .out_queued_count (out_queued_count),
    .error_count      (error_count),
    .pending_count    (pending_count),
    .result_count     (result_count),
    .popped_codes     (popped_codes),
    .dropped_codes    (dropped_codes)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, with a chance of 12 in a hundred. Changing ready on the
  // falling edge keeps it stable around the rising edge where the handshake is taken.
  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 12);
  end

  // Offers one item and returns at the rising edge where it is accepted. The task
  // always starts at a falling edge, so valid gets a single assignment per time step:
  // either it is lowered for an idle gap, or it stays high with the next payload.
  task automatic send_item(input pad_cmd_t cmd, input logic sample_ok, input logic [31:0] raw);
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_sample_valid <= sample_ok;
    in_raw_buttons  <= raw;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Random button word. Most words touch only the mapped buttons so that edges are
  // frequent; some carry junk in unmapped or masked-off bits, and a few are fully
  // random, which also sets the invalid flag about half of the time.
  function automatic logic [31:0] random_raw();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return $urandom;
    if (pick < 25) return $urandom & ~RAW_BAD_FLAG;
    return $urandom & RAW_BUTTON_MASK;
  endfunction

  initial begin
    int          random_items;
    int          pop_percent;
    logic [31:0] raw;
    logic        sample_ok;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A pop on an empty ring comes first; on a pop the sample fields
    // must not matter, so they are set to all ones here.
    send_item(CMD_POP, 1'b1, 32'hFFFF_FFFF);
    // A single press, then every mapped button: up is already held, so it is not
    // queued again, and the other seven follow in the fixed order.
    send_item(CMD_SAMPLE, 1'b1, RAW_UP);
    send_item(CMD_SAMPLE, 1'b1, RAW_BUTTON_MASK);
    // Both kinds of invalid sample must leave the previous buttons untouched.
    send_item(CMD_SAMPLE, 1'b0, 32'h0000_0000);
    send_item(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF);
    // Only bits above the 21-bit mask: counts as a full release.
    send_item(CMD_SAMPLE, 1'b1, 32'h7FE0_0000);
    // Escape through each of the two start buttons, with a release in between.
    send_item(CMD_SAMPLE, 1'b1, RAW_START_A);
    send_item(CMD_SAMPLE, 1'b1, 32'h0000_0000);
    send_item(CMD_SAMPLE, 1'b1, RAW_START_B);
    // Everything but the invalid flag: escape stays held, seven new presses, of which
    // the last two no longer fit and are dropped on the full ring.
    send_item(CMD_SAMPLE, 1'b1, 32'h7FFF_FFFF);
    // Drain the ring completely; sample fields are zero on the first pop.
    send_item(CMD_POP, 1'b0, 32'h0000_0000);
    repeat (14) send_item(CMD_POP, 1'($urandom_range(0, 1)), $urandom);

    // Random part, in runs of 16 items that either fill the ring, drain it or mix
    // both, so that the full and empty corners are visited again and again.
    // Invalid samples count toward the total like every other item.
    random_items = 0;
    pop_percent  = 40;
    while (random_items < 550) begin
      if (random_items % 16 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            pop_percent = 15;
          end
          1: begin
            pop_percent = 75;
          end
          default: begin
            pop_percent = 40;
          end
        endcase
      end
      // One long stretch without any idling on either side.
      steady_flow = (random_items >= 250 && random_items < 330);
      if ($urandom_range(0, 99) < pop_percent) begin
        send_item(CMD_POP, 1'($urandom_range(0, 1)), $urandom);
      end else begin
        raw       = random_raw();
        sample_ok = ($urandom_range(0, 99) >= 8);
        send_item(CMD_SAMPLE, sample_ok, raw);
      end
      random_items++;
    end

    @(negedge clk);
    in_valid    <= 1'b0;
    steady_flow = 1'b0;

    // Every item yields one result; wait for the last, then keep watching the output in case
    // the block produces anything extra.
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Summary: %0d items sent, %0d results checked.", items_sent, result_count);
    $display("Summary: %0d key codes popped, %0d presses dropped on a full ring.",
             popped_codes, dropped_codes);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: pad_edge_key_queue.f
rtl/pekq_pkg.sv
rtl/pekq_ram.sv
rtl/pad_edge_key_queue.sv
tb/sv/pekq_tb_pkg.sv
tb/sv/pekq_key_checker.sv
tb/sv/pad_edge_key_queue_tb.sv
